[rtl/lscmi_pkg.sv]
// ============================================================================
// lscmi_pkg
// Shared types, codes and constants of the lidar scan cost grid.
// ============================================================================
`default_nettype none

package lscmi_pkg;

  localparam int DEF_GRID_WIDTH  = 256;
  localparam int DEF_GRID_HEIGHT = 256;
  localparam int MAX_BEAMS         = 1024;
  localparam int MAX_INFLATE_CELLS = 16;

  localparam int COST_W = 7;
  localparam logic [COST_W-1:0] FULL_COST = 7'd100;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_MIN_RANGE   = 3'd2,
    REG_MAX_RANGE   = 3'd3,
    REG_ORIGIN_X    = 3'd4,
    REG_ORIGIN_Y    = 3'd5,
    REG_CELL_SIZE   = 3'd6,
    REG_INFL_RADIUS = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] RST_START_ANGLE = 16'h8000;
  localparam logic [11:0] RST_ANGLE_STEP  = 12'd182;
  localparam logic [15:0] RST_MIN_RANGE   = 16'd100;
  localparam logic [15:0] RST_MAX_RANGE   = 16'd30000;
  localparam logic [15:0] RST_ORIGIN_X    = 16'd0;
  localparam logic [15:0] RST_ORIGIN_Y    = 16'd0;
  localparam logic [9:0]  RST_CELL_SIZE   = 10'd100;
  localparam logic [13:0] RST_INFL_RADIUS = 14'd1000;

  localparam logic [16:0] SIN_C1  = 17'd102944;
  localparam logic [15:0] SIN_C2  = 16'd42048;
  localparam logic [12:0] SIN_C3  = 13'd4640;
  localparam logic [14:0] QUARTER = 15'd16384;

  localparam int COORD_W = 12;
  localparam int OFF_W   = 7;
  localparam int DIV_NW  = 18;
  localparam int DIV_DW  = 10;

  localparam int MUL_W      = 17;
  localparam int SQ_NW      = 50;
  localparam int SQRT_STEPS = 25;
  localparam int RAD_W      = 22;
  localparam int NUM_W      = 29;
  localparam int QUO_BITS   = 7;
  localparam int COST_LAT   = 3 + SQRT_STEPS + 1 + QUO_BITS;

endpackage

`default_nettype wire

[rtl/lscmi_div.sv]
// ============================================================================
// lscmi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module lscmi_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [lscmi_pkg::DIV_NW-1:0]  dividend,
  input  wire logic [lscmi_pkg::DIV_DW-1:0]  divisor,
  output logic                               done,
  output logic [lscmi_pkg::DIV_NW-1:0]       quotient
);

  localparam int CW = $clog2(lscmi_pkg::DIV_NW + 1);

  logic                            active;
  logic [CW-1:0]                   cnt;
  logic [lscmi_pkg::DIV_DW:0]      rem;
  logic [lscmi_pkg::DIV_DW-1:0]    dvs;
  logic [lscmi_pkg::DIV_DW+1:0]    shifted;
  logic                            fits;

  assign shifted = {rem, quotient[lscmi_pkg::DIV_NW-1]};
  assign fits    = shifted >= {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        cnt      <= CW'(lscmi_pkg::DIV_NW);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (active) begin
        if (fits) begin
          rem <= (lscmi_pkg::DIV_DW+1)'(shifted - {2'b00, dvs});
        end else begin
          rem <= shifted[lscmi_pkg::DIV_DW:0];
        end
        quotient <= {quotient[lscmi_pkg::DIV_NW-2:0], fits};
        cnt      <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lscmi_cost_pipe.sv]
// ============================================================================
// lscmi_cost_pipe
// Pipelined inflation cost of one cell offset: distance by square root,
// then the decaying cost by restoring division, one cell per cycle.
// ============================================================================
`default_nettype none

module lscmi_cost_pipe #(
  parameter int AW = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [AW-1:0]                  in_addr,
  input  wire logic [lscmi_pkg::OFF_W-1:0]    in_ax,
  input  wire logic [lscmi_pkg::OFF_W-1:0]    in_ay,
  input  wire logic [lscmi_pkg::DIV_DW-1:0]   cs,
  input  wire logic [lscmi_pkg::RAD_W-1:0]    rad,
  output logic                                out_valid,
  output logic [AW-1:0]                       out_addr,
  output logic [lscmi_pkg::COST_W-1:0]        out_cost
);

  localparam int SQ_NW = lscmi_pkg::SQ_NW;
  localparam int STEPS = lscmi_pkg::SQRT_STEPS;
  localparam int NUM_W = lscmi_pkg::NUM_W;
  localparam int QB    = lscmi_pkg::QUO_BITS;

  logic                          m_v, s_v;
  logic [AW-1:0]                 m_a, s_a;
  logic [lscmi_pkg::MUL_W-1:0]   mx, my;
  logic [2*lscmi_pkg::MUL_W-1:0] sx, sy;

  logic             sq_v   [0:STEPS];
  logic [AW-1:0]    sq_a   [0:STEPS];
  logic [SQ_NW-1:0] sq_n   [0:STEPS];
  logic [SQ_NW-1:0] sq_res [0:STEPS];

  logic             qs_v   [0:QB];
  logic [AW-1:0]    qs_a   [0:QB];
  logic [NUM_W-1:0] qs_rem [0:QB];
  logic [QB-1:0]    qs_q   [0:QB];

  logic [SQ_NW-1:0] d8;

  assign d8 = sq_res[STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v      <= 1'b0;
      s_v      <= 1'b0;
      sq_v[0]  <= 1'b0;
      qs_v[0]  <= 1'b0;
    end else begin
      m_v     <= in_valid;
      s_v     <= m_v;
      sq_v[0] <= s_v;
      qs_v[0] <= sq_v[STEPS] && (d8 <= SQ_NW'(rad));
    end
    m_a       <= in_addr;
    mx        <= lscmi_pkg::MUL_W'(in_ax) * lscmi_pkg::MUL_W'(cs);
    my        <= lscmi_pkg::MUL_W'(in_ay) * lscmi_pkg::MUL_W'(cs);
    s_a       <= m_a;
    sx        <= (2*lscmi_pkg::MUL_W)'(mx) * (2*lscmi_pkg::MUL_W)'(mx);
    sy        <= (2*lscmi_pkg::MUL_W)'(my) * (2*lscmi_pkg::MUL_W)'(my);
    sq_a[0]   <= s_a;
    sq_n[0]   <= SQ_NW'({(SQ_NW - 16)'(sx) + (SQ_NW - 16)'(sy), 16'b0});
    sq_res[0] <= '0;
    qs_a[0]   <= sq_a[STEPS];
    qs_rem[0] <= NUM_W'(7'd100) * NUM_W'(rad - d8[lscmi_pkg::RAD_W-1:0]);
    qs_q[0]   <= '0;
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_sqrt
    localparam logic [SQ_NW-1:0] BITV = SQ_NW'(1) << (2 * (STEPS - 1 - j));
    logic [SQ_NW-1:0] trial;
    assign trial = sq_res[j] + BITV;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else begin
        sq_v[j+1] <= sq_v[j];
      end
      sq_a[j+1] <= sq_a[j];
      if (sq_n[j] >= trial) begin
        sq_n[j+1]   <= sq_n[j] - trial;
        sq_res[j+1] <= (sq_res[j] >> 1) + BITV;
      end else begin
        sq_n[j+1]   <= sq_n[j];
        sq_res[j+1] <= sq_res[j] >> 1;
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_quo
    logic [NUM_W-1:0] dsub;
    assign dsub = NUM_W'(rad) << (QB - 1 - j);
    always_ff @(posedge clk) begin
      if (rst) begin
        qs_v[j+1] <= 1'b0;
      end else begin
        qs_v[j+1] <= qs_v[j];
      end
      qs_a[j+1] <= qs_a[j];
      if (qs_rem[j] >= dsub) begin
        qs_rem[j+1] <= qs_rem[j] - dsub;
        qs_q[j+1]   <= qs_q[j] | (QB'(1) << (QB - 1 - j));
      end else begin
        qs_rem[j+1] <= qs_rem[j];
        qs_q[j+1]   <= qs_q[j];
      end
    end
  end

  assign out_valid = qs_v[QB];
  assign out_addr  = qs_a[QB];
  assign out_cost  = lscmi_pkg::COST_W'(qs_q[QB]);

endmodule

`default_nettype wire

[rtl/lscmi_grid.sv]
// ============================================================================
// lscmi_grid
// Cost grid memory with a direct write port, a read port and a
// read-modify-write max merge for inflation updates.
// ============================================================================
`default_nettype none

module lscmi_grid #(
  parameter int CELLS = 65536,
  parameter int AW    = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_valid,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [lscmi_pkg::COST_W-1:0]  wr_data,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic [lscmi_pkg::COST_W-1:0]       rd_data,
  input  wire logic                          upd_valid,
  input  wire logic [AW-1:0]                 upd_addr,
  input  wire logic [lscmi_pkg::COST_W-1:0]  upd_cost
);

  logic [lscmi_pkg::COST_W-1:0] mem [0:CELLS-1];

  logic                          rmw_v;
  logic [AW-1:0]                 rmw_addr;
  logic [lscmi_pkg::COST_W-1:0]  rmw_cost;
  logic [AW-1:0]                 raddr;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [lscmi_pkg::COST_W-1:0]  wdata;

  assign raddr = rd_en ? rd_addr : upd_addr;
  assign we    = wr_valid || (rmw_v && (rmw_cost > rd_data));
  assign waddr = wr_valid ? wr_addr : rmw_addr;
  assign wdata = wr_valid ? wr_data : rmw_cost;

  always_ff @(posedge clk) begin
    rd_data <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmw_v <= 1'b0;
    end else begin
      rmw_v <= upd_valid;
    end
    rmw_addr <= upd_addr;
    rmw_cost <= upd_cost;
  end

endmodule

`default_nettype wire

[rtl/lidar_scan_costmap_inflation.sv]
// ============================================================================
// lidar_scan_costmap_inflation
// Obstacle cost grid built from lidar returns, with disc inflation.
// ============================================================================
// An item is taken when start is high and busy is low; its single result
// appears on cell_cost and sample_hit for exactly one cycle with done high,
// and the receiver cannot stall it. After reset the grid is swept to zero
// with busy high; a begin-scan item takes the same sweep, one cell per cycle
// through the memory write port. A sample runs the sine steps and the
// serial divisions for x and y; if it hits the grid, its cell is written at
// full cost and, with a nonzero inflation radius, a third division gives k,
// the inflation reach in cells, and the (2k+1)^2 cell offsets then stream
// through the cost pipeline and the read-modify-write port before the
// pipeline drains.
`default_nettype none

module lidar_scan_costmap_inflation #(
  parameter int GRID_WIDTH  = lscmi_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = lscmi_pkg::DEF_GRID_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic [1:0]  req_type,
  input  wire logic [9:0]  beam_index,
  input  wire logic [15:0] range_mm,
  input  wire logic        range_finite,
  input  wire logic [7:0]  read_x,
  input  wire logic [7:0]  read_y,
  output logic [6:0]       cell_cost,
  output logic             sample_hit,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CELLS     = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DRAIN_CYC = lscmi_pkg::COST_LAT + 3;
  localparam int DCW       = $clog2(DRAIN_CYC + 1);
  localparam int CW        = lscmi_pkg::COORD_W;
  localparam int NW        = lscmi_pkg::DIV_NW;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ANGLE, S_SIN_T, S_SIN_T2, S_SIN_IN, S_SIN_P, S_SIN_S,
    S_POS_X, S_POS_Y, S_DIV_GO, S_DIV_WAIT, S_HIT, S_SCAN, S_DRAIN,
    S_RD, S_RD_WAIT
  } state_t;

  typedef enum logic [1:0] {
    DSEL_X, DSEL_Y, DSEL_K
  } dsel_t;

  state_t state;
  dsel_t  div_sel;

  logic [15:0]        start_angle;
  logic [11:0]        angle_step;
  logic [15:0]        min_range;
  logic [15:0]        range_hi;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [9:0]         cell_size;
  logic [13:0]        infl_radius;

  logic [9:0]  beam_r;
  logic [15:0] rng_r;
  logic [7:0]  rx_r;
  logic [7:0]  ry_r;

  logic [15:0]        ang;
  logic               sin_ph;
  logic [14:0]        sn_t;
  logic               sn_neg;
  logic [14:0]        sn_t2;
  logic [12:0]        sn_in;
  logic [16:0]        sn_p;
  logic signed [18:0] cos_v;
  logic signed [18:0] sin_v;
  logic signed [36:0] px;
  logic signed [36:0] py;
  logic [NW-1:0]      qx;
  logic [CW-1:0]      gx;
  logic [CW-1:0]      gy;
  logic [lscmi_pkg::OFF_W-1:0] kp;
  logic signed [7:0]  dx;
  logic signed [7:0]  dy;
  logic [DCW-1:0]     drain_cnt;
  logic [AW-1:0]      clr_cnt;
  logic               clr_report;

  logic [15:0] sn_arg;
  logic [29:0] sn_tt;
  logic [27:0] sn_ip;
  logic [30:0] sn_mp;
  logic [31:0] sn_sp;
  logic [17:0] sn_sv;
  logic signed [18:0] sn_res;
  logic [21:0] ang_prod;

  logic [9:0]         cs_eff;
  logic signed [36:0] pxa;
  logic signed [36:0] pya;
  logic               div_start;
  logic [NW-1:0]      div_num;
  logic               div_done;
  logic [NW-1:0]      div_q;
  logic               x_in;
  logic               y_in;
  logic [lscmi_pkg::OFF_W-1:0] knew;
  logic signed [7:0]  kpos;

  logic signed [13:0] nx;
  logic signed [13:0] ny;
  logic               cell_ok;
  logic [lscmi_pkg::OFF_W-1:0] ax;
  logic [lscmi_pkg::OFF_W-1:0] ay;

  logic                          g_wr_valid;
  logic [AW-1:0]                 g_wr_addr;
  logic [lscmi_pkg::COST_W-1:0]  g_wr_data;
  logic                          g_rd_en;
  logic [lscmi_pkg::COST_W-1:0]  g_rd_data;
  logic                          p_valid;
  logic [AW-1:0]                 p_addr;
  logic [lscmi_pkg::COST_W-1:0]  p_cost;

  logic sample_ok;
  logic read_ok;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] y,
                                              input logic [CW-1:0] x);
    return AW'(32'(y) * GRID_WIDTH + 32'(x));
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign sample_ok = range_finite && (32'(beam_index) < lscmi_pkg::MAX_BEAMS) &&
                     (range_mm > min_range) && (range_mm < range_hi);
  assign read_ok   = (32'(read_x) < GRID_WIDTH) && (32'(read_y) < GRID_HEIGHT);

  assign ang_prod = 22'(beam_r) * 22'(angle_step);
  assign sn_arg   = sin_ph ? ang : ang + 16'(lscmi_pkg::QUARTER);
  assign sn_tt    = 30'(sn_t) * 30'(sn_t);
  assign sn_ip    = 28'(lscmi_pkg::SIN_C3) * 28'(sn_t2);
  assign sn_mp    = 31'(lscmi_pkg::SIN_C2 - 16'(sn_in)) * 31'(sn_t2);
  assign sn_sp    = 32'(sn_p) * 32'(sn_t);
  assign sn_sv    = sn_sp[31:14];
  assign sn_res   = sn_neg ? -$signed({1'b0, sn_sv}) : $signed({1'b0, sn_sv});

  assign cs_eff = (cell_size == '0) ? 10'd1 : cell_size;
  assign pxa    = px[36] ? -px : px;
  assign pya    = py[36] ? -py : py;

  always_comb begin
    case (div_sel)
      DSEL_X:  div_num = NW'(pxa[33:16]);
      DSEL_Y:  div_num = NW'(pya[33:16]);
      DSEL_K:  div_num = NW'(infl_radius) + NW'(cs_eff) - NW'(1);
      default: div_num = '0;
    endcase
  end

  assign div_start = (state == S_DIV_GO);

  assign x_in = (qx == '0) || (!px[36] && (32'(qx) < GRID_WIDTH));
  assign y_in = (div_q == '0) || (!py[36] && (32'(div_q) < GRID_HEIGHT));
  assign knew = (div_q > NW'(lscmi_pkg::MAX_INFLATE_CELLS)) ?
                lscmi_pkg::OFF_W'(lscmi_pkg::MAX_INFLATE_CELLS) :
                div_q[lscmi_pkg::OFF_W-1:0];
  assign kpos = $signed({1'b0, kp});

  assign nx      = $signed({2'b00, gx}) + 14'(dx);
  assign ny      = $signed({2'b00, gy}) + 14'(dy);
  assign cell_ok = !((dx == 8'sd0) && (dy == 8'sd0)) && (nx >= 14'sd0) &&
                   (ny >= 14'sd0) && (nx < GRID_WIDTH) && (ny < GRID_HEIGHT);
  assign ax      = dx[7] ? lscmi_pkg::OFF_W'(-dx) : lscmi_pkg::OFF_W'(dx);
  assign ay      = dy[7] ? lscmi_pkg::OFF_W'(-dy) : lscmi_pkg::OFF_W'(dy);

  assign g_wr_valid = (state == S_CLR) || (state == S_HIT);
  assign g_wr_addr  = (state == S_CLR) ? clr_cnt : cell_addr(gy, gx);
  assign g_wr_data  = (state == S_CLR) ? '0 : lscmi_pkg::FULL_COST;
  assign g_rd_en    = (state == S_RD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      div_sel     <= DSEL_X;
      clr_cnt     <= '0;
      clr_report  <= 1'b0;
      done        <= 1'b0;
      cell_cost   <= '0;
      sample_hit  <= 1'b0;
      start_angle <= lscmi_pkg::RST_START_ANGLE;
      angle_step  <= lscmi_pkg::RST_ANGLE_STEP;
      min_range   <= lscmi_pkg::RST_MIN_RANGE;
      range_hi    <= lscmi_pkg::RST_MAX_RANGE;
      origin_x    <= $signed(lscmi_pkg::RST_ORIGIN_X);
      origin_y    <= $signed(lscmi_pkg::RST_ORIGIN_Y);
      cell_size   <= lscmi_pkg::RST_CELL_SIZE;
      infl_radius <= lscmi_pkg::RST_INFL_RADIUS;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lscmi_pkg::REG_START_ANGLE: start_angle <= cfg_data;
          lscmi_pkg::REG_ANGLE_STEP:  angle_step  <= cfg_data[11:0];
          lscmi_pkg::REG_MIN_RANGE:   min_range   <= cfg_data;
          lscmi_pkg::REG_MAX_RANGE:   range_hi    <= cfg_data;
          lscmi_pkg::REG_ORIGIN_X:    origin_x    <= $signed(cfg_data);
          lscmi_pkg::REG_ORIGIN_Y:    origin_y    <= $signed(cfg_data);
          lscmi_pkg::REG_CELL_SIZE:   cell_size   <= cfg_data[9:0];
          lscmi_pkg::REG_INFL_RADIUS: infl_radius <= cfg_data[13:0];
          default: ;
        endcase
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(CELLS - 1)) begin
            clr_report <= 1'b0;
            state      <= S_IDLE;
            if (clr_report) begin
              done       <= 1'b1;
              cell_cost  <= '0;
              sample_hit <= 1'b0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            beam_r <= beam_index;
            rng_r  <= range_mm;
            rx_r   <= read_x;
            ry_r   <= read_y;
            case (req_type)
              lscmi_pkg::REQ_CLEAR: begin
                clr_cnt    <= '0;
                clr_report <= 1'b1;
                state      <= S_CLR;
              end
              lscmi_pkg::REQ_SAMPLE: begin
                if (sample_ok) begin
                  state <= S_ANGLE;
                end else begin
                  done       <= 1'b1;
                  cell_cost  <= '0;
                  sample_hit <= 1'b0;
                end
              end
              lscmi_pkg::REQ_READ: begin
                if (read_ok) begin
                  state <= S_RD;
                end else begin
                  done       <= 1'b1;
                  cell_cost  <= '0;
                  sample_hit <= 1'b0;
                end
              end
              default: begin
                done       <= 1'b1;
                cell_cost  <= '0;
                sample_hit <= 1'b0;
              end
            endcase
          end
        end
        S_ANGLE: begin
          ang    <= start_angle + ang_prod[15:0];
          sin_ph <= 1'b0;
          state  <= S_SIN_T;
        end
        S_SIN_T: begin
          sn_t   <= sn_arg[14] ? lscmi_pkg::QUARTER - {1'b0, sn_arg[13:0]}
                               : {1'b0, sn_arg[13:0]};
          sn_neg <= sn_arg[15];
          state  <= S_SIN_T2;
        end
        S_SIN_T2: begin
          sn_t2 <= sn_tt[28:14];
          state <= S_SIN_IN;
        end
        S_SIN_IN: begin
          sn_in <= sn_ip[26:14];
          state <= S_SIN_P;
        end
        S_SIN_P: begin
          sn_p  <= lscmi_pkg::SIN_C1 - sn_mp[30:14];
          state <= S_SIN_S;
        end
        S_SIN_S: begin
          if (!sin_ph) begin
            cos_v  <= sn_res;
            sin_ph <= 1'b1;
            state  <= S_SIN_T;
          end else begin
            sin_v <= sn_res;
            state <= S_POS_X;
          end
        end
        S_POS_X: begin
          px    <= $signed({21'b0, rng_r}) * 37'(cos_v) -
                   $signed({{5{origin_x[15]}}, origin_x, 16'b0});
          state <= S_POS_Y;
        end
        S_POS_Y: begin
          py      <= $signed({21'b0, rng_r}) * 37'(sin_v) -
                     $signed({{5{origin_y[15]}}, origin_y, 16'b0});
          div_sel <= DSEL_X;
          state   <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (div_sel)
              DSEL_X: begin
                qx      <= div_q;
                div_sel <= DSEL_Y;
                state   <= S_DIV_GO;
              end
              DSEL_Y: begin
                if (x_in && y_in) begin
                  gx    <= px[36] ? '0 : CW'(qx);
                  gy    <= py[36] ? '0 : CW'(div_q);
                  state <= S_HIT;
                end else begin
                  done       <= 1'b1;
                  cell_cost  <= '0;
                  sample_hit <= 1'b0;
                  state      <= S_IDLE;
                end
              end
              DSEL_K: begin
                kp    <= knew;
                dx    <= -$signed({1'b0, knew});
                dy    <= -$signed({1'b0, knew});
                state <= S_SCAN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_HIT: begin
          if (infl_radius == '0) begin
            done       <= 1'b1;
            cell_cost  <= '0;
            sample_hit <= 1'b1;
            state      <= S_IDLE;
          end else begin
            div_sel <= DSEL_K;
            state   <= S_DIV_GO;
          end
        end
        S_SCAN: begin
          if (dx == kpos) begin
            dx <= -kpos;
            if (dy == kpos) begin
              drain_cnt <= DCW'(DRAIN_CYC);
              state     <= S_DRAIN;
            end else begin
              dy <= dy + 8'sd1;
            end
          end else begin
            dx <= dx + 8'sd1;
          end
        end
        S_DRAIN: begin
          if (drain_cnt == '0) begin
            done       <= 1'b1;
            cell_cost  <= '0;
            sample_hit <= 1'b1;
            state      <= S_IDLE;
          end else begin
            drain_cnt <= drain_cnt - DCW'(1);
          end
        end
        S_RD: begin
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          done       <= 1'b1;
          cell_cost  <= g_rd_data;
          sample_hit <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lscmi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (cs_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  lscmi_cost_pipe #(
    .AW (AW)
  ) u_cost (
    .clk       (clk),
    .rst       (rst),
    .in_valid  ((state == S_SCAN) && cell_ok),
    .in_addr   (cell_addr(ny[CW-1:0], nx[CW-1:0])),
    .in_ax     (ax),
    .in_ay     (ay),
    .cs        (cs_eff),
    .rad       ({infl_radius, 8'b0}),
    .out_valid (p_valid),
    .out_addr  (p_addr),
    .out_cost  (p_cost)
  );

  lscmi_grid #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_grid (
    .clk       (clk),
    .rst       (rst),
    .wr_valid  (g_wr_valid),
    .wr_addr   (g_wr_addr),
    .wr_data   (g_wr_data),
    .rd_en     (g_rd_en),
    .rd_addr   (cell_addr(CW'(ry_r), CW'(rx_r))),
    .rd_data   (g_rd_data),
    .upd_valid (p_valid),
    .upd_addr  (p_addr),
    .upd_cost  (p_cost)
  );

endmodule

`default_nettype wire
